>>> hw/rtl/sdci_pkg.sv
// ----------------------------------------------------------------------------
// sdci_pkg
// Types, constants and lookup functions for the SD card init sequencer.
// ----------------------------------------------------------------------------
package sdci_pkg;

    // Sequencer phase, one-hot. A waiting phase names the command just issued.
    typedef enum logic [12:0] {
        PH_IDLE   = 13'b0000000000001,
        PH_CMD0   = 13'b0000000000010,
        PH_CMD8   = 13'b0000000000100,
        PH_APP41  = 13'b0000000001000,
        PH_ACMD41 = 13'b0000000010000,
        PH_CMD2   = 13'b0000000100000,
        PH_CMD3   = 13'b0000001000000,
        PH_CMD9   = 13'b0000010000000,
        PH_CMD7   = 13'b0000100000000,
        PH_APP6   = 13'b0001000000000,
        PH_ACMD6  = 13'b0010000000000,
        PH_DONE   = 13'b0100000000000,
        PH_FAIL   = 13'b1000000000000
    } t_phase;

    typedef enum logic [1:0] {
        RK_NONE     = 2'd0,
        RK_SHORT    = 2'd1,
        RK_SHORT_NC = 2'd2,
        RK_LONG     = 2'd3
    } t_resp_kind;

    // input beat codes
    localparam logic ITEM_START    = 1'b0;
    localparam logic ITEM_RESPONSE = 1'b1;

    // SD command numbers
    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_ALL_CID   = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
    localparam logic [5:0] CMD_SET_BUS   = 6'd6;
    localparam logic [5:0] CMD_SELECT    = 6'd7;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;

    localparam logic [31:0] IF_COND_PATTERN  = 32'h0000_01AA;
    localparam logic [31:0] APP_READY_STATUS = 32'h0000_0120;
    localparam logic [20:0] CAP_MAX          = 21'h1F_FFFF;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_RETRY_LIMIT  = 2'd0;
    localparam logic [1:0] REG_OP_COND_ARG  = 2'd1;
    localparam logic [1:0] REG_OP_COND_EXP  = 2'd2;
    localparam logic [1:0] REG_BUS_WIDTH    = 2'd3;

    localparam logic [15:0] RST_RETRY_LIMIT = 16'd1000;
    localparam logic [31:0] RST_OP_COND_ARG = 32'h50FF_8000;
    localparam logic [31:0] RST_OP_COND_EXP = 32'hC0FF_8000;
    localparam logic [1:0]  RST_BUS_WIDTH   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] status;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_item;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic [31:0] op_cond_arg;
        logic [31:0] op_cond_exp;
        logic [1:0]  bus_width;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] retry_count;
        logic [15:0] card_address;
        logic        capacity_class;
        logic [20:0] capacity;
        logic [7:0]  maker;
        logic [31:0] serial;
    } t_state;

    typedef struct packed {
        logic        issue;
        logic [5:0]  command_index;
        t_resp_kind  response_kind;
        logic [31:0] argument;
        logic        finished;
        logic        failed;
        logic [15:0] card_address;
        logic        high_capacity;
        logic [20:0] capacity_mbyte;
        logic [7:0]  maker_code;
        logic [31:0] product_serial;
    } t_result;

    function automatic logic [5:0] phase_index(input t_phase ph);
        logic [5:0] idx;
        case (ph)
            PH_CMD8:   idx = CMD_IF_COND;
            PH_APP41:  idx = CMD_APP;
            PH_ACMD41: idx = CMD_OP_COND;
            PH_CMD2:   idx = CMD_ALL_CID;
            PH_CMD3:   idx = CMD_SEND_RCA;
            PH_CMD9:   idx = CMD_SEND_CSD;
            PH_CMD7:   idx = CMD_SELECT;
            PH_APP6:   idx = CMD_APP;
            PH_ACMD6:  idx = CMD_SET_BUS;
            default:   idx = CMD_GO_IDLE;
        endcase
        return idx;
    endfunction

    function automatic t_resp_kind phase_kind(input t_phase ph);
        t_resp_kind k;
        case (ph)
            PH_ACMD41:                  k = RK_SHORT_NC;
            PH_CMD2, PH_CMD9:           k = RK_LONG;
            PH_CMD8, PH_APP41, PH_CMD3,
            PH_CMD7, PH_APP6, PH_ACMD6: k = RK_SHORT;
            default:                    k = RK_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/sdci_step.sv
// ----------------------------------------------------------------------------
// sdci_step
// Next-state and result logic for one beat of the init sequencer.
// ----------------------------------------------------------------------------
module sdci_step
    import sdci_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    t_state      n_st;
    t_phase      nxt;
    logic        issue;
    logic        ok;
    logic [31:0] arg;
    logic [16:0] cnt;
    logic [22:0] csize_p1;
    logic [21:0] mbyte;
    t_resp_kind  kind;

    assign kind     = phase_kind(i_state.phase);
    assign cnt      = {1'b0, i_state.retry_count} + 17'd1;
    assign csize_p1 = {1'b0, i_item.w1[5:0], i_item.w2[31:16]} + 23'd1;
    assign mbyte    = csize_p1[22:1];

    // success: sent (no response) or response received, and no error bit
    always_comb begin
        ok = (kind == RK_NONE) ? i_item.status[7] : i_item.status[6];
        if (i_item.status[1] || i_item.status[3]) begin
            ok = 1'b0;
        end
    end

    always_comb begin
        n_st  = i_state;
        nxt   = PH_FAIL;
        issue = 1'b0;
        arg   = '0;
        if (i_item.cmd == ITEM_START) begin
            n_st.retry_count    = '0;
            n_st.card_address   = '0;
            n_st.capacity_class = 1'b0;
            n_st.capacity       = '0;
            n_st.maker          = '0;
            n_st.serial         = '0;
            nxt   = PH_CMD0;
            issue = 1'b1;
        end else if (i_state.phase == PH_IDLE || i_state.phase == PH_DONE ||
                     i_state.phase == PH_FAIL) begin
            nxt = i_state.phase;
        end else if (ok) begin
            issue = 1'b1;
            case (i_state.phase)
                PH_CMD0: begin
                    nxt = PH_CMD8;
                    arg = IF_COND_PATTERN;
                end
                PH_CMD8: begin
                    if (i_item.w0 == IF_COND_PATTERN) begin
                        n_st.retry_count = '0;
                        nxt = PH_APP41;
                    end else begin
                        issue = 1'b0;
                    end
                end
                PH_APP41: begin
                    if (i_item.w0 == APP_READY_STATUS) begin
                        nxt = PH_ACMD41;
                        arg = i_cfg.op_cond_arg;
                    end else begin
                        issue = 1'b0;
                    end
                end
                PH_ACMD41: begin
                    if (i_item.w0 == i_cfg.op_cond_exp) begin
                        nxt = PH_CMD2;
                    end else if (cnt > {1'b0, i_cfg.retry_limit}) begin
                        issue = 1'b0;
                    end else begin
                        n_st.retry_count = cnt[15:0];
                        nxt = PH_APP41;
                    end
                end
                PH_CMD2: begin
                    n_st.maker  = i_item.w0[31:24];
                    n_st.serial = {i_item.w2[23:0], i_item.w3[31:24]};
                    nxt = PH_CMD3;
                end
                PH_CMD3: begin
                    n_st.card_address = i_item.w0[31:16];
                    nxt = PH_CMD9;
                    arg = {i_item.w0[31:16], 16'h0000};
                end
                PH_CMD9: begin
                    n_st.capacity_class = i_item.w0[30];
                    n_st.capacity = mbyte[21] ? CAP_MAX : mbyte[20:0];
                    nxt = PH_CMD7;
                    arg = {i_state.card_address, 16'h0000};
                end
                PH_CMD7: begin
                    nxt = PH_APP6;
                    arg = {i_state.card_address, 16'h0000};
                end
                PH_APP6: begin
                    nxt = PH_ACMD6;
                    arg = {30'd0, i_cfg.bus_width};
                end
                default: begin
                    nxt   = PH_DONE;
                    issue = 1'b0;
                end
            endcase
        end
        // a step that issues nothing ends in failure, unless it finished or was idle
        if (!issue && nxt != PH_DONE && nxt != PH_IDLE && i_item.cmd == ITEM_RESPONSE) begin
            nxt = (i_state.phase == PH_IDLE || i_state.phase == PH_DONE) ?
                  i_state.phase : PH_FAIL;
        end
        n_st.phase = nxt;
    end

    assign o_state = n_st;

    always_comb begin
        o_result.issue          = issue;
        o_result.command_index  = issue ? phase_index(nxt) : CMD_GO_IDLE;
        o_result.response_kind  = issue ? phase_kind(nxt) : RK_NONE;
        o_result.argument       = issue ? arg : 32'd0;
        o_result.finished       = (nxt == PH_DONE);
        o_result.failed         = (nxt == PH_FAIL);
        o_result.card_address   = n_st.card_address;
        o_result.high_capacity  = n_st.capacity_class;
        o_result.capacity_mbyte = n_st.capacity;
        o_result.maker_code     = n_st.maker;
        o_result.product_serial = n_st.serial;
    end

endmodule

>>> hw/rtl/sd_card_init_sequencer.sv
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// Host-side SD card bring-up sequencer: CMD0 .. ACMD6 command chain.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid/o_ready): one beat per event. i_cmd = 0 starts
//    (or restarts) bring-up and clears all stored card data; i_cmd = 1 hands
//    over the controller status and response words of the last command.
//  - Output channel (o_valid/i_ready): exactly one result beat per input
//    beat, in order. o_issue asks the host to send o_command_index with
//    o_argument; o_finished / o_failed report the end of the sequence. The
//    card fields (RCA, capacity class, MByte, maker, serial) ride along.
//  - APB port: retry_limit @0x0, ACMD41 argument @0x4, ACMD41 expected
//    answer @0x8, ACMD6 bus width @0xC. Write only while idle; pready is 1.
//  - Each beat passes the input register, then the result register; the
//    step logic between them is combinational. Throughput: one beat per
//    cycle while the receiver keeps i_ready high; a stall holds the flow.
//  - Reset (synchronous, active low): phase idle, card data zero, config
//    registers to their defaults, both channels empty.
//  - A stalled receiver holds the result register; the input register
//    still takes one more beat, then o_ready drops until the result drains.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer
    import sdci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_status,
    input  logic [31:0] i_resp_word0,
    input  logic [31:0] i_resp_word1,
    input  logic [31:0] i_resp_word2,
    input  logic [31:0] i_resp_word3,
    // result beats
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_issue,
    output logic [5:0]  o_command_index,
    output logic [1:0]  o_response_kind,
    output logic [31:0] o_argument,
    output logic        o_finished,
    output logic        o_failed,
    output logic [15:0] o_card_address_out,
    output logic        o_high_capacity,
    output logic [20:0] o_capacity_mbyte,
    output logic [7:0]  o_maker_code,
    output logic [31:0] o_product_serial,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    in_take;
    logic    step;      // input register moves into the result register
    logic    cfg_wr;

    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;
    assign in_take = i_valid && o_ready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit <= RST_RETRY_LIMIT;
            r_cfg.op_cond_arg <= RST_OP_COND_ARG;
            r_cfg.op_cond_exp <= RST_OP_COND_EXP;
            r_cfg.bus_width   <= RST_BUS_WIDTH;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RETRY_LIMIT: r_cfg.retry_limit <= pwdata[15:0];
                REG_OP_COND_ARG: r_cfg.op_cond_arg <= pwdata;
                REG_OP_COND_EXP: r_cfg.op_cond_exp <= pwdata;
                REG_BUS_WIDTH:   r_cfg.bus_width   <= pwdata[1:0];
                default:         r_cfg.bus_width   <= r_cfg.bus_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RETRY_LIMIT: prdata = {16'd0, r_cfg.retry_limit};
            REG_OP_COND_ARG: prdata = r_cfg.op_cond_arg;
            REG_OP_COND_EXP: prdata = r_cfg.op_cond_exp;
            REG_BUS_WIDTH:   prdata = {30'd0, r_cfg.bus_width};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd    <= i_cmd;
            r_in.status <= i_status;
            r_in.w0     <= i_resp_word0;
            r_in.w1     <= i_resp_word1;
            r_in.w2     <= i_resp_word2;
            r_in.w3     <= i_resp_word3;
        end
    end

    // ---------------- step logic ----------------
    sdci_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // sequencer state commits together with the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.retry_count    <= '0;
            r_state.card_address   <= '0;
            r_state.capacity_class <= 1'b0;
            r_state.capacity       <= '0;
            r_state.maker          <= '0;
            r_state.serial         <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_issue            = r_out.issue;
    assign o_command_index    = r_out.command_index;
    assign o_response_kind    = r_out.response_kind;
    assign o_argument         = r_out.argument;
    assign o_finished         = r_out.finished;
    assign o_failed           = r_out.failed;
    assign o_card_address_out = r_out.card_address;
    assign o_high_capacity    = r_out.high_capacity;
    assign o_capacity_mbyte   = r_out.capacity_mbyte;
    assign o_maker_code       = r_out.maker_code;
    assign o_product_serial   = r_out.product_serial;

`ifndef SYNTHESIS
    // a step always yields a result beat next cycle
    a_step_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("step did not produce a result beat");

    // finished and failed are exclusive
    a_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_finished && o_failed))
        else $error("finished and failed both set");

    // no command fields without issue
    a_quiet_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_issue) |-> (o_command_index == CMD_GO_IDLE &&
                                   o_response_kind == RK_NONE && o_argument == 32'd0))
        else $error("command fields set without issue");

    // a terminal result never asks for a command
    a_end_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_finished || o_failed)) |-> !o_issue)
        else $error("issue with terminal status");

    // state only moves with a step
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(step) && $past(i_rst_n) |-> $stable(r_state))
        else $error("sequencer state changed without a step");
`endif

endmodule

>>> tb/sv/tb_sd_card_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_card_init_sequencer
// Self-checking bench for the SD card bring-up sequencer. Scripted card
// answers walk the CMD0 .. ACMD6 chain with random content, injected faults,
// ACMD41 retries, early restarts and stray beats, under four register
// settings. A bench-side sequencer model predicts every result beat, and
// each beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_sd_card_init_sequencer;
    import sdci_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int ITEMS_PER_SETTING = 75;

    // ways a card answer can go wrong
    typedef enum int {
        FAULT_BIT1,     // controller error bit 1
        FAULT_BIT3,     // controller error bit 3
        FAULT_NO_ACK,   // sent / received flag missing
        FAULT_WORD      // response word not the expected pattern (CMD8 / CMD55), else error bit 1
    } t_fault;

    // one step of a scripted bring-up: the phase answered, and for ACMD41
    // whether the card reports ready
    typedef struct {
        t_phase ph;
        bit     ready;
    } t_script_step;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd   = 1'b0;
    logic [31:0] i_status     = '0;
    logic [31:0] i_resp_word0 = '0;
    logic [31:0] i_resp_word1 = '0;
    logic [31:0] i_resp_word2 = '0;
    logic [31:0] i_resp_word3 = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_issue;
    logic [5:0]  o_command_index;
    logic [1:0]  o_response_kind;
    logic [31:0] o_argument;
    logic        o_finished;
    logic        o_failed;
    logic [15:0] o_card_address_out;
    logic        o_high_capacity;
    logic [20:0] o_capacity_mbyte;
    logic [7:0]  o_maker_code;
    logic [31:0] o_product_serial;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    sd_card_init_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_status           (i_status),
        .i_resp_word0       (i_resp_word0),
        .i_resp_word1       (i_resp_word1),
        .i_resp_word2       (i_resp_word2),
        .i_resp_word3       (i_resp_word3),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_issue            (o_issue),
        .o_command_index    (o_command_index),
        .o_response_kind    (o_response_kind),
        .o_argument         (o_argument),
        .o_finished         (o_finished),
        .o_failed           (o_failed),
        .o_card_address_out (o_card_address_out),
        .o_high_capacity    (o_high_capacity),
        .o_capacity_mbyte   (o_capacity_mbyte),
        .o_maker_code       (o_maker_code),
        .o_product_serial   (o_product_serial),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench-side copy of the sequencer: register settings and card state
    // ------------------------------------------------------------------
    logic [15:0] retry_lim_cfg;
    logic [31:0] op_cond_arg_cfg;
    logic [31:0] op_cond_exp_cfg;
    logic [1:0]  bus_width_cfg;

    t_phase      seq_phase;
    logic [15:0] acmd41_tries;
    logic [15:0] card_rca;
    logic        card_hc;
    logic [20:0] card_mbyte;
    logic [7:0]  card_maker;
    logic [31:0] card_serial;

    t_item   sd_event_q[$];        // card events waiting to be driven
    t_item   sd_event;             // event currently on the input port
    t_result predicted_step_q[$];  // sequencer outputs still to come

    int items_queued  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 32;
    int rx_stall_pct  = 32;

    // command number and response kind of the command a phase waits on
    function automatic logic [7:0] cmd_slot(input t_phase ph);
        case (ph)
            PH_CMD8:   return {CMD_IF_COND,  RK_SHORT};
            PH_APP41:  return {CMD_APP,      RK_SHORT};
            PH_ACMD41: return {CMD_OP_COND,  RK_SHORT_NC};
            PH_CMD2:   return {CMD_ALL_CID,  RK_LONG};
            PH_CMD3:   return {CMD_SEND_RCA, RK_SHORT};
            PH_CMD9:   return {CMD_SEND_CSD, RK_LONG};
            PH_CMD7:   return {CMD_SELECT,   RK_SHORT};
            PH_APP6:   return {CMD_APP,      RK_SHORT};
            PH_ACMD6:  return {CMD_SET_BUS,  RK_SHORT};
            default:   return {CMD_GO_IDLE,  RK_NONE};
        endcase
    endfunction

    // One sequencer step: consumes a card event, updates the bench state and
    // returns the result beat the block must produce for it.
    function automatic t_result predict_init_step(input t_item it);
        t_result     r;
        t_phase      nxt;
        logic [31:0] arg;
        logic        go;
        logic        ack;
        logic [16:0] tries;
        logic [21:0] csize;
        logic [22:0] csize_p1;
        logic [7:0]  slot;
        nxt = PH_FAIL;
        arg = '0;
        go  = 1'b0;
        if (it.cmd == ITEM_START) begin
            // restart from any phase wipes the card record
            acmd41_tries = '0;
            card_rca     = '0;
            card_hc      = 1'b0;
            card_mbyte   = '0;
            card_maker   = '0;
            card_serial  = '0;
            nxt = PH_CMD0;
            go  = 1'b1;
        end else if (seq_phase inside {PH_IDLE, PH_DONE, PH_FAIL}) begin
            nxt = seq_phase;    // nothing outstanding, answer ignored
        end else begin
            slot = cmd_slot(seq_phase);
            // CMD0 has no response: judge on "sent"; otherwise on "received"
            ack = (t_resp_kind'(slot[1:0]) == RK_NONE) ? it.status[7] : it.status[6];
            if (it.status[1] || it.status[3])
                ack = 1'b0;
            if (ack) begin
                go = 1'b1;
                case (seq_phase)
                    PH_CMD0: begin
                        nxt = PH_CMD8;
                        arg = IF_COND_PATTERN;
                    end
                    PH_CMD8: begin
                        if (it.w0 == IF_COND_PATTERN) begin
                            acmd41_tries = '0;
                            nxt = PH_APP41;
                        end else begin
                            go = 1'b0;
                        end
                    end
                    PH_APP41: begin
                        if (it.w0 == APP_READY_STATUS) begin
                            nxt = PH_ACMD41;
                            arg = op_cond_arg_cfg;
                        end else begin
                            go = 1'b0;
                        end
                    end
                    PH_ACMD41: begin
                        if (it.w0 == op_cond_exp_cfg) begin
                            nxt = PH_CMD2;
                        end else begin
                            // card busy: retry until the count passes the limit
                            tries = {1'b0, acmd41_tries} + 17'd1;
                            if (tries > {1'b0, retry_lim_cfg}) begin
                                go = 1'b0;
                            end else begin
                                acmd41_tries = tries[15:0];
                                nxt = PH_APP41;
                            end
                        end
                    end
                    PH_CMD2: begin
                        card_maker  = it.w0[31:24];
                        card_serial = {it.w2[23:0], it.w3[31:24]};
                        nxt = PH_CMD3;
                    end
                    PH_CMD3: begin
                        card_rca = it.w0[31:16];
                        nxt = PH_CMD9;
                        arg = {card_rca, 16'h0};
                    end
                    PH_CMD9: begin
                        // CSD v2: C_SIZE in bits 69..48, half a MByte per unit
                        csize    = {it.w1[5:0], it.w2[31:16]};
                        csize_p1 = {1'b0, csize} + 23'd1;
                        card_hc  = it.w0[30];
                        card_mbyte = (csize_p1[22:1] > {1'b0, CAP_MAX}) ?
                                     CAP_MAX : csize_p1[21:1];
                        nxt = PH_CMD7;
                        arg = {card_rca, 16'h0};
                    end
                    PH_CMD7: begin
                        nxt = PH_APP6;
                        arg = {card_rca, 16'h0};
                    end
                    PH_APP6: begin
                        nxt = PH_ACMD6;
                        arg = {30'h0, bus_width_cfg};
                    end
                    default: begin
                        nxt = PH_DONE;
                        go  = 1'b0;
                    end
                endcase
            end
        end
        if (!go && nxt != PH_DONE && nxt != PH_IDLE && it.cmd != ITEM_START)
            nxt = (seq_phase == PH_IDLE || seq_phase == PH_DONE) ? seq_phase : PH_FAIL;
        seq_phase = nxt;

        slot = cmd_slot(nxt);
        r.issue          = go;
        r.command_index  = go ? slot[7:2] : 6'd0;
        r.response_kind  = go ? t_resp_kind'(slot[1:0]) : RK_NONE;
        r.argument       = go ? arg : 32'h0;
        r.finished       = (nxt == PH_DONE);
        r.failed         = (nxt == PH_FAIL);
        r.card_address   = card_rca;
        r.high_capacity  = card_hc;
        r.capacity_mbyte = card_mbyte;
        r.maker_code     = card_maker;
        r.product_serial = card_serial;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Card event generation
    // ------------------------------------------------------------------
    function automatic t_item noise_item();
        t_item it;
        it.cmd    = ITEM_RESPONSE;
        it.status = $urandom;
        it.w0     = $urandom;
        it.w1     = $urandom;
        it.w2     = $urandom;
        it.w3     = $urandom;
        return it;
    endfunction

    // a clean answer to the command the given phase waits on
    function automatic t_item card_answer(input t_phase ph, input bit ready);
        t_item it;
        it = noise_item();
        it.status[1] = 1'b0;
        it.status[3] = 1'b0;
        if (ph == PH_CMD0)
            it.status[7] = 1'b1;
        else
            it.status[6] = 1'b1;
        case (ph)
            PH_CMD8:  it.w0 = IF_COND_PATTERN;
            PH_APP41: it.w0 = APP_READY_STATUS;
            PH_ACMD41: begin
                if (ready)
                    it.w0 = op_cond_exp_cfg;
                else if (it.w0 == op_cond_exp_cfg)
                    it.w0 = ~it.w0;
            end
            PH_CMD9: begin
                // push C_SIZE to its ends now and then: saturation and zero
                case ($urandom_range(3))
                    0: begin
                        it.w1[5:0]   = 6'h3F;
                        it.w2[31:16] = 16'hFFFF;
                    end
                    1: begin
                        it.w1[5:0]   = 6'h00;
                        it.w2[31:16] = 16'h0000;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic enqueue(input t_item it);
        sd_event_q.push_back(it);
        items_queued++;
    endtask

    // Start beat plus the answers of a whole bring-up. not_ready busy ACMD41
    // answers come first; past the retry limit the script ends at the abort.
    // break_at: script step that gets a fault (then up to two stray beats).
    // cut_at: script step where the sequence is dropped for a restart.
    task automatic queue_bringup(input int not_ready, input int break_at,
                                 input t_fault fault, input int cut_at);
        t_script_step script[$];
        t_item        it;
        int           pairs;
        pairs = (not_ready > retry_lim_cfg) ? retry_lim_cfg + 1 : not_ready;
        script.push_back('{PH_CMD0, 1'b1});
        script.push_back('{PH_CMD8, 1'b1});
        for (int k = 0; k < pairs; k++) begin
            script.push_back('{PH_APP41, 1'b1});
            script.push_back('{PH_ACMD41, 1'b0});
        end
        if (not_ready <= retry_lim_cfg) begin
            script.push_back('{PH_APP41, 1'b1});
            script.push_back('{PH_ACMD41, 1'b1});
            script.push_back('{PH_CMD2, 1'b1});
            script.push_back('{PH_CMD3, 1'b1});
            script.push_back('{PH_CMD9, 1'b1});
            script.push_back('{PH_CMD7, 1'b1});
            script.push_back('{PH_APP6, 1'b1});
            script.push_back('{PH_ACMD6, 1'b1});
        end
        it = noise_item();
        it.cmd = ITEM_START;
        enqueue(it);
        foreach (script[i]) begin
            if (i == cut_at)
                return;
            it = card_answer(script[i].ph, script[i].ready);
            if (i == break_at) begin
                case (fault)
                    FAULT_BIT1: it.status[1] = 1'b1;
                    FAULT_BIT3: it.status[3] = 1'b1;
                    FAULT_NO_ACK: begin
                        if (script[i].ph == PH_CMD0)
                            it.status[7] = 1'b0;
                        else
                            it.status[6] = 1'b0;
                    end
                    default: begin
                        if (script[i].ph == PH_CMD8 || script[i].ph == PH_APP41)
                            it.w0 = it.w0 ^ (32'h1 << $urandom_range(31));
                        else
                            it.status[1] = 1'b1;
                    end
                endcase
                enqueue(it);
                repeat ($urandom_range(2)) enqueue(noise_item());
                return;
            end
            enqueue(it);
        end
    endtask

    // mostly well-formed bring-ups with random retries, faults and restarts
    task automatic run_random(input int quota);
        int nr, len, brk, cut, goal;
        goal = items_queued + quota;
        while (items_queued < goal) begin
            if ($urandom_range(19) == 0) begin
                enqueue(noise_item());
                continue;
            end
            if (retry_lim_cfg <= 8 && $urandom_range(3) == 0)
                nr = retry_lim_cfg + 1;
            else
                nr = $urandom_range(3);
            len = (nr > retry_lim_cfg) ? 2 + 2 * nr : 10 + 2 * nr;
            brk = ($urandom_range(99) < 30) ? $urandom_range(len - 1) : -1;
            cut = ($urandom_range(99) < 10) ? $urandom_range(1, len - 1) : -1;
            queue_bringup(nr, brk, t_fault'($urandom_range(3)), cut);
        end
    endtask

    // block idle: nothing queued, nothing on the port, nothing outstanding
    task automatic wait_drained();
        while (sd_event_q.size() != 0 || i_valid || predicted_step_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RETRY_LIMIT: retry_lim_cfg   = value[15:0];
            REG_OP_COND_ARG: op_cond_arg_cfg = value;
            REG_OP_COND_EXP: op_cond_exp_cfg = value;
            default:         bus_width_cfg   = value[1:0];
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: presents queued events; the event is predicted at the
    // edge where it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                predicted_step_q.push_back(predict_init_step(sd_event));
            if (!i_valid || o_ready) begin
                if (sd_event_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    sd_event     = sd_event_q.pop_front();
                    i_cmd        <= sd_event.cmd;
                    i_status     <= sd_event.status;
                    i_resp_word0 <= sd_event.w0;
                    i_resp_word1 <= sd_event.w1;
                    i_resp_word2 <= sd_event.w2;
                    i_resp_word3 <= sd_event.w3;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order field check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_monitor
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (predicted_step_q.size() == 0) begin
                flag_mismatch("beat with nothing expected", 32'h0, 32'h0);
            end else begin
                want = predicted_step_q.pop_front();
                if (o_issue !== want.issue)
                    flag_mismatch("issue", o_issue, want.issue);
                if (o_command_index !== want.command_index)
                    flag_mismatch("command_index", o_command_index, want.command_index);
                if (o_response_kind !== want.response_kind)
                    flag_mismatch("response_kind", o_response_kind, want.response_kind);
                if (o_argument !== want.argument)
                    flag_mismatch("argument", o_argument, want.argument);
                if (o_finished !== want.finished)
                    flag_mismatch("finished", o_finished, want.finished);
                if (o_failed !== want.failed)
                    flag_mismatch("failed", o_failed, want.failed);
                if (o_card_address_out !== want.card_address)
                    flag_mismatch("card_address_out", o_card_address_out,
                                  want.card_address);
                if (o_high_capacity !== want.high_capacity)
                    flag_mismatch("high_capacity", o_high_capacity, want.high_capacity);
                if (o_capacity_mbyte !== want.capacity_mbyte)
                    flag_mismatch("capacity_mbyte", o_capacity_mbyte, want.capacity_mbyte);
                if (o_maker_code !== want.maker_code)
                    flag_mismatch("maker_code", o_maker_code, want.maker_code);
                if (o_product_serial !== want.product_serial)
                    flag_mismatch("product_serial", o_product_serial,
                                  want.product_serial);
            end
        end
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sd_card_init_sequencer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        retry_lim_cfg   = RST_RETRY_LIMIT;
        op_cond_arg_cfg = RST_OP_COND_ARG;
        op_cond_exp_cfg = RST_OP_COND_EXP;
        bus_width_cfg   = RST_BUS_WIDTH;
        seq_phase       = PH_IDLE;
        acmd41_tries    = '0;
        card_rca        = '0;
        card_hc         = 1'b0;
        card_mbyte      = '0;
        card_maker      = '0;
        card_serial     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: answer while idle, clean bring-up with one busy ACMD41,
        // answer after done, bad CMD8 pattern, CMD0 error bit, bad CMD55
        // status word, restart in the middle of the chain
        enqueue(noise_item());
        queue_bringup(1, -1, FAULT_BIT1, -1);
        enqueue(noise_item());
        queue_bringup(0, 1, FAULT_WORD, -1);
        queue_bringup(0, 0, FAULT_BIT3, -1);
        queue_bringup(0, 2, FAULT_WORD, -1);
        queue_bringup(0, -1, FAULT_BIT1, 6);
        run_random(ITEMS_PER_SETTING);

        // register settings: low extremes, high extremes (no idling at all),
        // a random mix with a short retry limit, then back to defaults
        for (int s = 0; s < 4; s++) begin
            wait_drained();
            case (s)
                0: begin
                    csr_write(REG_RETRY_LIMIT, 32'd1);
                    csr_write(REG_OP_COND_ARG, 32'h0);
                    csr_write(REG_OP_COND_EXP, 32'h0);
                    csr_write(REG_BUS_WIDTH,   32'd0);
                end
                1: begin
                    csr_write(REG_RETRY_LIMIT, 32'h0000_FFFF);
                    csr_write(REG_OP_COND_ARG, 32'hFFFF_FFFF);
                    csr_write(REG_OP_COND_EXP, 32'hFFFF_FFFF);
                    csr_write(REG_BUS_WIDTH,   32'd3);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                2: begin
                    csr_write(REG_RETRY_LIMIT, $urandom_range(2, 6));
                    csr_write(REG_OP_COND_ARG, $urandom);
                    csr_write(REG_OP_COND_EXP, $urandom);
                    csr_write(REG_BUS_WIDTH,   32'd1);
                end
                default: begin
                    csr_write(REG_RETRY_LIMIT, {16'h0, RST_RETRY_LIMIT});
                    csr_write(REG_OP_COND_ARG, RST_OP_COND_ARG);
                    csr_write(REG_OP_COND_EXP, RST_OP_COND_EXP);
                    csr_write(REG_BUS_WIDTH,   {30'h0, RST_BUS_WIDTH});
                end
            endcase
            run_random(ITEMS_PER_SETTING);
            wait_drained();
            tx_idle_pct  = 32;
            rx_stall_pct = 32;
        end

        wait_drained();
        if (mismatches == 0 && predicted_step_q.size() == 0) begin
            $display("sd_card_init_sequencer regression: pass");
        end else begin
            $display("sd_card_init_sequencer regression: fail");
        end
        $finish;
    end

endmodule
